### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the ECDH key-exchange parser.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TEPP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define TEPP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);
`else
`define TEPP_ASSERT(lbl, clk, rst_n, prop, msg)
`define TEPP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### hdl/tepp_pkg.sv
// Types and codes for the ECDH key-exchange parser.
// No dependencies; imported by tls_ecdh_params_parser_core.
package tepp_pkg;

    localparam logic [1:0] CMD_NEXT   = 2'd0;
    localparam logic [1:0] CMD_SERVER = 2'd1;
    localparam logic [1:0] CMD_CLIENT = 2'd2;

    localparam logic [3:0] FK_CURVE_TYPE = 4'd0;
    localparam logic [3:0] FK_CURVE_HI   = 4'd1;
    localparam logic [3:0] FK_CURVE_LO   = 4'd2;
    localparam logic [3:0] FK_POINT_LEN  = 4'd3;
    localparam logic [3:0] FK_POINT      = 4'd4;
    localparam logic [3:0] FK_HASH_ALGO  = 4'd5;
    localparam logic [3:0] FK_SIG_ALGO   = 4'd6;
    localparam logic [3:0] FK_HLEN_HI    = 4'd7;
    localparam logic [3:0] FK_HLEN_LO    = 4'd8;
    localparam logic [3:0] FK_HASH       = 4'd9;
    localparam logic [3:0] FK_TRAILING   = 4'd10;
    localparam logic [3:0] FK_SKIPPED    = 4'd11;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_POINT_LONG = 2'd1;
    localparam logic [1:0] ERR_HASH_LONG  = 2'd2;
    localparam logic [1:0] ERR_BEYOND_LEN = 2'd3;

    localparam logic [7:0]  CURVE_TYPE_NAMED = 8'd3;
    localparam logic [15:0] CURVE_NAMED_END  = 16'd26;
    localparam logic [15:0] CURVE_EXTRA_A    = 16'hFF01;
    localparam logic [15:0] CURVE_EXTRA_B    = 16'hFF02;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CTYPE,
        PH_CURVE_HI,
        PH_CURVE_LO,
        PH_PLEN,
        PH_POINT,
        PH_HALGO,
        PH_SALGO,
        PH_HLEN_HI,
        PH_HLEN_LO,
        PH_HASH,
        PH_TRAIL,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic [15:0] msg_length;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [7:0]  data_out;
        logic        field_last;
        logic [15:0] curve_id;
        logic        curve_known;
        logic [7:0]  point_length;
        logic [15:0] hash_length;
        logic [1:0]  error_code;
        logic        message_done;
    } t_out_word;

endpackage

### hdl/tls_ecdh_params_parser_core.sv
// ECDH key-exchange message parser: classes each byte by field, one word per cycle while results are taken.
// Depends on tepp_pkg and assert_macros.svh.
//
//  channel  valid        ready        word
//  input    i_in_valid   o_in_ready   i_in_word  (cmd, data_byte, msg_length)
//  output   o_out_valid  i_out_ready  o_out_word (field class and saved values)
//
// One input word per cycle while results are taken; a byte's result appears in the cycle after acceptance.
// The phase, counter and result word are computed in a single combinational pass and registered together.
// Start commands update state and give no result; unused commands are ignored and give no result.
// o_in_ready drops only while a held result is not taken.
// Reset returns the parser to idle with all saved values cleared.
module tls_ecdh_params_parser_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tepp_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tepp_pkg::t_out_word  o_out_word
);
    import tepp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_bytes_remaining, n_bytes_remaining;
    logic [15:0] r_field_remaining, n_field_remaining;
    logic [7:0]  r_high_byte_latch, n_high_byte_latch;
    logic [15:0] r_saved_curve, n_saved_curve;
    logic [7:0]  r_saved_point_len, n_saved_point_len;
    logic [15:0] r_saved_hash_len, n_saved_hash_len;
    logic        r_is_client, n_is_client;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out_word, n_out_word;

    logic        w_accept;
    logic        w_result;
    logic [7:0]  w_byte;
    logic [15:0] w_rem;
    logic [15:0] w_hash_len;
    logic [3:0]  w_kind;
    logic        w_last;
    logic [1:0]  w_err;
    logic        w_done;
    logic        w_known;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_result    = w_accept && (i_in_word.cmd == CMD_NEXT);
    assign w_byte      = i_in_word.data_byte;
    assign w_rem       = r_bytes_remaining - 16'd1;
    assign w_hash_len  = {r_high_byte_latch, w_byte};
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_phase           = r_phase;
        n_bytes_remaining = r_bytes_remaining;
        n_field_remaining = r_field_remaining;
        n_high_byte_latch = r_high_byte_latch;
        n_saved_curve     = r_saved_curve;
        n_saved_point_len = r_saved_point_len;
        n_saved_hash_len  = r_saved_hash_len;
        n_is_client       = r_is_client;
        w_kind            = FK_SKIPPED;
        w_last            = 1'b0;
        w_err             = ERR_NONE;
        w_done            = 1'b0;
        if (w_accept) begin
            case (i_in_word.cmd)
                CMD_SERVER, CMD_CLIENT: begin
                    n_field_remaining = '0;
                    n_high_byte_latch = '0;
                    n_saved_curve     = '0;
                    n_saved_point_len = '0;
                    n_saved_hash_len  = '0;
                    n_bytes_remaining = i_in_word.msg_length;
                    n_is_client       = (i_in_word.cmd == CMD_CLIENT);
                    n_phase           = (i_in_word.cmd == CMD_CLIENT) ? PH_PLEN : PH_CTYPE;
                end
                CMD_NEXT: begin
                    if (r_phase == PH_IDLE) begin
                        w_kind = FK_SKIPPED;
                    end else if (r_bytes_remaining == 16'd0) begin
                        w_kind  = FK_TRAILING;
                        w_err   = ERR_BEYOND_LEN;
                        n_phase = PH_IDLE;
                    end else begin
                        n_bytes_remaining = w_rem;
                        case (r_phase)
                            PH_CTYPE: begin
                                w_kind = FK_CURVE_TYPE;
                                w_last = 1'b1;
                                if (w_byte == CURVE_TYPE_NAMED) begin
                                    n_phase = PH_CURVE_HI;
                                end else begin
                                    n_phase = PH_SKIP;
                                    w_done  = 1'b1;
                                end
                            end
                            PH_CURVE_HI: begin
                                w_kind            = FK_CURVE_HI;
                                n_high_byte_latch = w_byte;
                                n_phase           = PH_CURVE_LO;
                            end
                            PH_CURVE_LO: begin
                                w_kind        = FK_CURVE_LO;
                                w_last        = 1'b1;
                                n_saved_curve = {r_high_byte_latch, w_byte};
                                n_phase       = PH_PLEN;
                            end
                            PH_PLEN: begin
                                w_kind            = FK_POINT_LEN;
                                w_last            = 1'b1;
                                n_saved_point_len = w_byte;
                                if ({8'd0, w_byte} > w_rem) begin
                                    w_err   = ERR_POINT_LONG;
                                    n_phase = PH_IDLE;
                                end else if (w_byte == 8'd0) begin
                                    w_done  = r_is_client;
                                    n_phase = r_is_client ? PH_TRAIL : PH_HALGO;
                                end else begin
                                    n_field_remaining = {8'd0, w_byte};
                                    n_phase           = PH_POINT;
                                end
                            end
                            PH_POINT: begin
                                w_kind            = FK_POINT;
                                n_field_remaining = r_field_remaining - 16'd1;
                                if (r_field_remaining == 16'd1) begin
                                    w_last  = 1'b1;
                                    w_done  = r_is_client;
                                    n_phase = r_is_client ? PH_TRAIL : PH_HALGO;
                                end
                            end
                            PH_HALGO: begin
                                w_kind  = FK_HASH_ALGO;
                                w_last  = 1'b1;
                                n_phase = PH_SALGO;
                            end
                            PH_SALGO: begin
                                w_kind  = FK_SIG_ALGO;
                                w_last  = 1'b1;
                                n_phase = PH_HLEN_HI;
                            end
                            PH_HLEN_HI: begin
                                w_kind            = FK_HLEN_HI;
                                n_high_byte_latch = w_byte;
                                n_phase           = PH_HLEN_LO;
                            end
                            PH_HLEN_LO: begin
                                w_kind           = FK_HLEN_LO;
                                w_last           = 1'b1;
                                n_saved_hash_len = w_hash_len;
                                if (w_hash_len > w_rem) begin
                                    w_err   = ERR_HASH_LONG;
                                    n_phase = PH_IDLE;
                                end else if (w_hash_len == 16'd0) begin
                                    w_done  = 1'b1;
                                    n_phase = PH_TRAIL;
                                end else begin
                                    n_field_remaining = w_hash_len;
                                    n_phase           = PH_HASH;
                                end
                            end
                            PH_HASH: begin
                                w_kind            = FK_HASH;
                                n_field_remaining = r_field_remaining - 16'd1;
                                if (r_field_remaining == 16'd1) begin
                                    w_last  = 1'b1;
                                    w_done  = 1'b1;
                                    n_phase = PH_TRAIL;
                                end
                            end
                            PH_TRAIL: begin
                                w_kind = FK_TRAILING;
                            end
                            default: begin
                                w_kind = FK_SKIPPED;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_known = ((n_saved_curve != 16'd0) && (n_saved_curve < CURVE_NAMED_END))
               || (n_saved_curve == CURVE_EXTRA_A) || (n_saved_curve == CURVE_EXTRA_B);
        n_out_word.field_kind   = w_kind;
        n_out_word.data_out     = w_byte;
        n_out_word.field_last   = w_last;
        n_out_word.curve_id     = n_saved_curve;
        n_out_word.curve_known  = w_known;
        n_out_word.point_length = n_saved_point_len;
        n_out_word.hash_length  = n_saved_hash_len;
        n_out_word.error_code   = w_err;
        n_out_word.message_done = w_done;
        n_out_valid             = w_result ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_bytes_remaining <= '0;
            r_field_remaining <= '0;
            r_high_byte_latch <= '0;
            r_saved_curve     <= '0;
            r_saved_point_len <= '0;
            r_saved_hash_len  <= '0;
            r_is_client       <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_phase           <= n_phase;
            r_bytes_remaining <= n_bytes_remaining;
            r_field_remaining <= n_field_remaining;
            r_high_byte_latch <= n_high_byte_latch;
            r_saved_curve     <= n_saved_curve;
            r_saved_point_len <= n_saved_point_len;
            r_saved_hash_len  <= n_saved_hash_len;
            r_is_client       <= n_is_client;
            r_out_valid       <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_out_word <= n_out_word;
        end
    end

`include "assert_macros.svh"

    `TEPP_ASSERT(a_err_goes_idle, i_clk, i_rst_n, (w_result && (w_err != ERR_NONE)) |=> (r_phase == PH_IDLE), "error did not stop parsing")
    `TEPP_ASSERT(a_field_count_live, i_clk, i_rst_n, ((r_phase == PH_POINT) || (r_phase == PH_HASH)) |-> (r_field_remaining != 16'd0), "field count empty inside a field")
    `TEPP_ASSERT(a_done_is_last, i_clk, i_rst_n, (r_out_valid && r_out_word.message_done) |-> r_out_word.field_last, "message done off a field end")
    `TEPP_ASSERT(a_start_no_result, i_clk, i_rst_n, (w_accept && (i_in_word.cmd != CMD_NEXT)) |=> !r_out_valid, "command word produced a result")

endmodule

### test/tb_tls_ecdh_params_parser_core.sv
// Self-checking testbench for tls_ecdh_params_parser_core: server and client key-exchange
// messages, broken lengths and noise, with a bytewise field predictor and random handshake stalls.
// Depends on tepp_pkg and the RTL of the parser core.
module tb_tls_ecdh_params_parser_core;
    timeunit 1ns;
    timeprecision 1ps;
    import tepp_pkg::*;

    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int unsigned RANDOM_WORDS = 550;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef logic [7:0] byte_list_t[$];

    class ecdh_field_scoreboard;
        t_phase      phase;
        logic [15:0] bytes_left;
        logic [15:0] field_left;
        logic [7:0]  high_latch;
        logic [15:0] saved_curve;
        logic [7:0]  saved_point_len;
        logic [15:0] saved_hash_len;
        bit          client_form;
        t_out_word   expected_q[$];
        int unsigned errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            phase           = PH_IDLE;
            bytes_left      = '0;
            field_left      = '0;
            high_latch      = '0;
            saved_curve     = '0;
            saved_point_len = '0;
            saved_hash_len  = '0;
            client_form     = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function bit finish_point();
            if (client_form) begin
                phase = PH_TRAIL;
                return 1'b1;
            end
            phase = PH_HALGO;
            return 1'b0;
        endfunction

        function void note_input(t_in_word w);
            t_out_word r;
            if (w.cmd == CMD_SERVER || w.cmd == CMD_CLIENT) begin
                clear();
                bytes_left  = w.msg_length;
                client_form = (w.cmd == CMD_CLIENT);
                phase       = client_form ? PH_PLEN : PH_CTYPE;
                return;
            end
            if (w.cmd != CMD_NEXT) return;
            r            = '0;
            r.field_kind = FK_SKIPPED;
            r.data_out   = w.data_byte;
            r.error_code = ERR_NONE;
            if (phase == PH_IDLE) begin
                r.field_kind = FK_SKIPPED;
            end else if (bytes_left == 16'd0) begin
                r.field_kind = FK_TRAILING;
                r.error_code = ERR_BEYOND_LEN;
                phase        = PH_IDLE;
            end else begin
                bytes_left = bytes_left - 16'd1;
                case (phase)
                    PH_CTYPE: begin
                        r.field_kind = FK_CURVE_TYPE;
                        r.field_last = 1'b1;
                        if (w.data_byte == CURVE_TYPE_NAMED) begin
                            phase = PH_CURVE_HI;
                        end else begin
                            phase          = PH_SKIP;
                            r.message_done = 1'b1;
                        end
                    end
                    PH_CURVE_HI: begin
                        r.field_kind = FK_CURVE_HI;
                        high_latch   = w.data_byte;
                        phase        = PH_CURVE_LO;
                    end
                    PH_CURVE_LO: begin
                        r.field_kind = FK_CURVE_LO;
                        r.field_last = 1'b1;
                        saved_curve  = {high_latch, w.data_byte};
                        phase        = PH_PLEN;
                    end
                    PH_PLEN: begin
                        r.field_kind    = FK_POINT_LEN;
                        r.field_last    = 1'b1;
                        saved_point_len = w.data_byte;
                        if ({8'd0, w.data_byte} > bytes_left) begin
                            r.error_code = ERR_POINT_LONG;
                            phase        = PH_IDLE;
                        end else if (w.data_byte == 8'd0) begin
                            r.message_done = finish_point();
                        end else begin
                            field_left = {8'd0, w.data_byte};
                            phase      = PH_POINT;
                        end
                    end
                    PH_POINT: begin
                        r.field_kind = FK_POINT;
                        field_left   = field_left - 16'd1;
                        if (field_left == 16'd0) begin
                            r.field_last   = 1'b1;
                            r.message_done = finish_point();
                        end
                    end
                    PH_HALGO: begin
                        r.field_kind = FK_HASH_ALGO;
                        r.field_last = 1'b1;
                        phase        = PH_SALGO;
                    end
                    PH_SALGO: begin
                        r.field_kind = FK_SIG_ALGO;
                        r.field_last = 1'b1;
                        phase        = PH_HLEN_HI;
                    end
                    PH_HLEN_HI: begin
                        r.field_kind = FK_HLEN_HI;
                        high_latch   = w.data_byte;
                        phase        = PH_HLEN_LO;
                    end
                    PH_HLEN_LO: begin
                        r.field_kind   = FK_HLEN_LO;
                        r.field_last   = 1'b1;
                        saved_hash_len = {high_latch, w.data_byte};
                        if (saved_hash_len > bytes_left) begin
                            r.error_code = ERR_HASH_LONG;
                            phase        = PH_IDLE;
                        end else if (saved_hash_len == 16'd0) begin
                            r.message_done = 1'b1;
                            phase          = PH_TRAIL;
                        end else begin
                            field_left = saved_hash_len;
                            phase      = PH_HASH;
                        end
                    end
                    PH_HASH: begin
                        r.field_kind = FK_HASH;
                        field_left   = field_left - 16'd1;
                        if (field_left == 16'd0) begin
                            r.field_last   = 1'b1;
                            r.message_done = 1'b1;
                            phase          = PH_TRAIL;
                        end
                    end
                    PH_TRAIL: r.field_kind = FK_TRAILING;
                    default:  r.field_kind = FK_SKIPPED;
                endcase
            end
            r.curve_id     = saved_curve;
            r.curve_known  = (saved_curve >= 16'd1 && saved_curve < CURVE_NAMED_END) ||
                             saved_curve == CURVE_EXTRA_A || saved_curve == CURVE_EXTRA_B;
            r.point_length = saved_point_len;
            r.hash_length  = saved_hash_len;
            expected_q.push_back(r);
        endfunction

        function void report(string name, logic [15:0] want, logic [15:0] got);
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            errors++;
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.field_kind !== want.field_kind)
                report("field_kind", want.field_kind, got.field_kind);
            if (got.data_out !== want.data_out)
                report("data_out", want.data_out, got.data_out);
            if (got.field_last !== want.field_last)
                report("field_last", want.field_last, got.field_last);
            if (got.curve_id !== want.curve_id)
                report("curve_id", want.curve_id, got.curve_id);
            if (got.curve_known !== want.curve_known)
                report("curve_known", want.curve_known, got.curve_known);
            if (got.point_length !== want.point_length)
                report("point_length", want.point_length, got.point_length);
            if (got.hash_length !== want.hash_length)
                report("hash_length", want.hash_length, got.hash_length);
            if (got.error_code !== want.error_code)
                report("error_code", want.error_code, got.error_code);
            if (got.message_done !== want.message_done)
                report("message_done", want.message_done, got.message_done);
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    ecdh_field_scoreboard sb;
    bit          hold_off_req = 1'b0;
    bit          send_calm    = 1'b0;
    int unsigned word_count   = 0;
    int unsigned quiet_cycles = 0;

    tls_ecdh_params_parser_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out_word);
            if (i_in_valid && o_in_ready) sb.note_input(i_in_word);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        bit calm;
        calm = 1'b0;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 19) == 0) calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 6);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall        = LONG_HOLD;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    task automatic offer(input t_in_word w);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (w.cmd != CMD_UNUSED) word_count++;
    endtask

    task automatic give_byte(input logic [7:0] b);
        t_in_word w;
        w.cmd        = CMD_NEXT;
        w.data_byte  = b;
        w.msg_length = 16'($urandom);
        offer(w);
    endtask

    task automatic give_start(input logic [1:0] cmd, input logic [15:0] len);
        t_in_word w;
        w.cmd        = cmd;
        w.data_byte  = 8'($urandom);
        w.msg_length = len;
        offer(w);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic send_message(input logic [1:0] start_cmd, input byte_list_t body);
        logic [15:0] len;
        int unsigned n;
        if ($urandom_range(0, 9) < 7) begin
            len = 16'(body.size() + $urandom_range(0, 3));
            n   = len + (($urandom_range(0, 4) == 0) ? 1 : 0);
        end else begin
            len = 16'($urandom_range(0, body.size()));
            n   = len + $urandom_range(0, 2);
        end
        give_start(start_cmd, len);
        for (int i = 0; i < n; i++) give_byte(i < body.size() ? body[i] : 8'($urandom));
    endtask

    function automatic logic [7:0] pick_point_len();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    endfunction

    task automatic server_msg();
        byte_list_t  body;
        logic [7:0]  plen;
        logic [15:0] curve;
        logic [15:0] hlen;
        case ($urandom_range(0, 6))
            0:       curve = 16'($urandom_range(1, 25));
            1:       curve = CURVE_EXTRA_A;
            2:       curve = CURVE_EXTRA_B;
            3:       curve = $urandom_range(0, 1) ? 16'd0 : CURVE_NAMED_END;
            4:       curve = $urandom_range(0, 1) ? 16'hFF00 : 16'hFF03;
            default: curve = 16'($urandom);
        endcase
        body.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : CURVE_TYPE_NAMED);
        body.push_back(curve[15:8]);
        body.push_back(curve[7:0]);
        plen = pick_point_len();
        body.push_back(plen);
        if (plen <= 8'd40) begin
            repeat (plen) body.push_back(8'($urandom));
            body.push_back(8'($urandom));
            body.push_back(8'($urandom));
            hlen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(256, 65535))
                                               : 16'($urandom_range(0, 8));
            body.push_back(hlen[15:8]);
            body.push_back(hlen[7:0]);
            if (hlen < 16'd256) repeat (hlen) body.push_back(8'($urandom));
        end
        send_message(CMD_SERVER, body);
    endtask

    task automatic client_msg();
        byte_list_t body;
        logic [7:0] plen;
        plen = pick_point_len();
        body.push_back(plen);
        if (plen <= 8'd40) repeat (plen) body.push_back(8'($urandom));
        send_message(CMD_CLIENT, body);
    endtask

    task automatic noise_burst();
        t_in_word w;
        repeat ($urandom_range(1, 4)) begin
            w.cmd        = 2'($urandom_range(0, 3));
            w.data_byte  = 8'($urandom);
            w.msg_length = 16'($urandom);
            offer(w);
        end
    endtask

    initial begin : stimulus
        int unsigned msg;
        int unsigned pick;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        give_byte(8'hFF);
        give_byte(8'h00);
        offer('{cmd: CMD_UNUSED, data_byte: 8'hA5, msg_length: 16'hFFFF});
        give_start(CMD_SERVER, 16'd0);
        give_byte(CURVE_TYPE_NAMED);
        give_start(CMD_CLIENT, 16'd2);
        give_byte(8'h00);
        give_byte(8'h5A);
        give_byte(8'hC3);
        give_start(CMD_CLIENT, 16'd1);
        give_byte(8'h05);
        give_byte(8'h77);
        give_start(CMD_SERVER, 16'd2);
        give_byte(8'h01);
        give_byte(8'h42);
        give_start(CMD_SERVER, 16'd8);
        give_byte(CURVE_TYPE_NAMED);
        give_byte(8'h00);
        give_byte(8'h17);
        give_byte(8'h00);
        give_byte(8'h04);
        give_byte(8'h01);
        give_byte(8'hFF);
        give_byte(8'hFF);

        word_count = 0;
        msg        = 0;
        while (word_count < RANDOM_WORDS) begin
            if (msg == 8) hold_off_req = 1'b1;
            if (msg == 20) drain_results();
            pick = $urandom_range(0, 9);
            if (pick < 6) server_msg();
            else if (pick < 9) client_msg();
            else noise_burst();
            msg++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
